### src/mrrpm_pkg.sv
package mrrpm_pkg;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int SEL_W   = 2;
  localparam int SLOT_W  = 10;
  localparam int OVR_W   = 32;
  localparam int ACTV_W  = 3;

  localparam logic [OVR_W-1:0]  OVR_MAX     = '1;
  localparam logic [ACTV_W-1:0] ACTV_RESET  = ACTV_W'(1);

  // Request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_STATUS   = 2'd0,
    CMD_ADV_HEAD = 2'd1,
    CMD_ADV_TAIL = 2'd2,
    CMD_FLUSH    = 2'd3
  } cmd_t;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take request, apply command, restart scan
    logic scan_step;  // fold one reader into the occupancy max
    logic load_out;   // move status into the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

  // Low slot bits of a zero-extended index
  function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] v);
    slot_of = v[SLOT_W-1:0];
  endfunction

endpackage

### src/mrrpm_req_if.sv
interface mrrpm_req_if;
  logic                         valid;
  logic                         ready;
  logic [mrrpm_pkg::CMD_W-1:0]  cmd;
  logic [mrrpm_pkg::SEL_W-1:0]  reader_select;

  modport source (output valid, output cmd, output reader_select, input ready);
  modport sink   (input valid, input cmd, input reader_select, output ready);
endinterface

### src/mrrpm_rsp_if.sv
interface mrrpm_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mrrpm_pkg::SLOT_W-1:0] head_slot;
  logic [mrrpm_pkg::SLOT_W-1:0] tail_slot;
  logic                         reader_empty;
  logic                         full_flag;
  logic [mrrpm_pkg::OVR_W-1:0]  overrun_count;
  logic [mrrpm_pkg::SLOT_W-1:0] used_slots;

  modport source (output valid, output head_slot, output tail_slot, output reader_empty,
                  output full_flag, output overrun_count, output used_slots, input ready);
  modport sink   (input valid, input head_slot, input tail_slot, input reader_empty,
                  input full_flag, input overrun_count, input used_slots, output ready);
endinterface

### src/mrrpm_cfg_if.sv
interface mrrpm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mrrpm_pkg::ACTV_W-1:0] active_readers;

  modport source (output valid, output active_readers, input ready);
  modport sink   (input valid, input active_readers, output ready);
endinterface

### src/multi_reader_ring_pointer_manager.sv
// Pointer manager for a ring with one writer and up to MAX_READERS readers.
//
// req (sink): cmd and reader_select. Commands are status only, advance head,
//   advance the selected reader's tail, and flush all tails to the head.
// rsp (source): one status result per request, with values after the
//   command: head and selected tail slots, empty, full, overrun count and
//   the largest occupancy over the active readers.
// cfg (sink): writes active_readers; ready out of reset, write only while idle.
//
// Timing: a request is applied at the edge it is accepted, then the
// occupancy is found by a scan that visits one active reader per cycle.
// The result is registered once the scan of the clipped active reader
// count ends, and the next request is taken only after that load.
// Reset (rst, synchronous) zeroes head, tails, full and overrun, sets
// active_readers to 1 and empties the result register. While rsp is
// stalled the finished result is held and one more request may be accepted
// and scanned; it then waits for the result register to drain.
module multi_reader_ring_pointer_manager #(
  parameter int DEPTH       = 1024,
  parameter int MAX_READERS = 4
) (
  input logic          clk,
  input logic          rst,
  mrrpm_req_if.sink    req,
  mrrpm_rsp_if.source  rsp,
  mrrpm_cfg_if.sink    cfg
);
  import mrrpm_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  assign cfg.ready = !rst;

  // Sequencer
  mrrpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Pointers, scan and result register
  mrrpm_dp #(
    .DEPTH       (DEPTH),
    .MAX_READERS (MAX_READERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .req_cmd       (req.cmd),
    .req_sel       (req.reader_select),
    .cfg_we        (cfg.valid),
    .cfg_data      (cfg.active_readers),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .head_slot     (rsp.head_slot),
    .tail_slot     (rsp.tail_slot),
    .reader_empty  (rsp.reader_empty),
    .full_flag     (rsp.full_flag),
    .overrun_count (rsp.overrun_count),
    .used_slots    (rsp.used_slots)
  );

endmodule

### src/mrrpm_ctrl.sv
module mrrpm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mrrpm_pkg::ctrl_sts_t  sts,
  output mrrpm_pkg::ctrl_cmd_t  ctl
);
  import mrrpm_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done && sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs; no request is taken while in reset
  always_comb begin
    in_ready      = 1'b0;
    ctl.accept    = 1'b0;
    ctl.scan_step = 1'b0;
    ctl.load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = !rst;
        ctl.accept = in_valid && !rst;
      end
      ST_SCAN: begin
        ctl.scan_step = !sts.scan_done;
        ctl.load_out  = sts.scan_done && sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### src/mrrpm_dp.sv
module mrrpm_dp #(
  parameter int DEPTH       = 1024,
  parameter int MAX_READERS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mrrpm_pkg::ctrl_cmd_t          ctl,
  output mrrpm_pkg::ctrl_sts_t          sts,
  // request payload
  input  logic [mrrpm_pkg::CMD_W-1:0]   req_cmd,
  input  logic [mrrpm_pkg::SEL_W-1:0]   req_sel,
  // register write
  input  logic                          cfg_we,
  input  logic [mrrpm_pkg::ACTV_W-1:0]  cfg_data,
  // result side
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [mrrpm_pkg::SLOT_W-1:0]  head_slot,
  output logic [mrrpm_pkg::SLOT_W-1:0]  tail_slot,
  output logic                          reader_empty,
  output logic                          full_flag,
  output logic [mrrpm_pkg::OVR_W-1:0]   overrun_count,
  output logic [mrrpm_pkg::SLOT_W-1:0]  used_slots
);
  import mrrpm_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(MAX_READERS + 1);

  // Pointer state
  logic [IW-1:0]     head;
  logic [IW-1:0]     tails [MAX_READERS];
  logic              full_mark;
  logic [OVR_W-1:0]  overrun;
  logic [ACTV_W-1:0] active_readers;

  // Scan state
  logic [SEL_W-1:0]  sel_q;
  logic [CW-1:0]     scan_idx;
  logic [IW-1:0]     used_acc;

  cmd_t          cmd;
  logic [CW-1:0] n_act;
  logic [IW-1:0] head_inc;
  logic          blocked;
  logic          sel_ok_in;
  logic [IW-1:0] tail_in;
  logic [IW-1:0] tail_in_inc;
  logic [IW-1:0] scan_tail;
  logic [IW-1:0] scan_dist;
  logic          sel_ok_q;
  logic [IW-1:0] tail_q;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] x);
    logic [IW:0] s;
    s = {1'b0, x} + (IW+1)'(1);
    if (s >= (IW+1)'(DEPTH)) next_slot = '0;
    else                     next_slot = s[IW-1:0];
  endfunction

  assign cmd = cmd_t'(req_cmd);

  // Effective reader count, clipped to the number built
  always_comb begin
    if (32'(active_readers) > MAX_READERS) n_act = CW'(MAX_READERS);
    else                                   n_act = CW'(active_readers);
  end

  // Head advance check against every active tail
  assign head_inc = next_slot(head);
  always_comb begin
    blocked = 1'b0;
    for (int i = 0; i < MAX_READERS; i++) begin
      if (CW'(i) < n_act && tails[i] == head_inc) blocked = 1'b1;
    end
  end

  // Tail of the requested reader
  assign sel_ok_in = 32'(req_sel) < MAX_READERS;
  always_comb begin
    tail_in = head;
    for (int i = 0; i < MAX_READERS; i++) begin
      if (32'(req_sel) == i) tail_in = tails[i];
    end
  end
  assign tail_in_inc = next_slot(tail_in);

  // Tail under the scan pointer and its distance behind head
  always_comb begin
    scan_tail = head;
    for (int i = 0; i < MAX_READERS; i++) begin
      if (scan_idx == CW'(i)) scan_tail = tails[i];
    end
  end
  always_comb begin
    logic [IW:0] wrap;
    wrap = ({1'b0, head} + (IW+1)'(DEPTH)) - {1'b0, scan_tail};
    if (head >= scan_tail) scan_dist = head - scan_tail;
    else                   scan_dist = wrap[IW-1:0];
  end

  // Reported reader's tail
  assign sel_ok_q = 32'(sel_q) < MAX_READERS;
  always_comb begin
    tail_q = head;
    for (int i = 0; i < MAX_READERS; i++) begin
      if (sel_ok_q && 32'(sel_q) == i) tail_q = tails[i];
    end
  end

  assign sts.scan_done = scan_idx >= n_act;
  assign sts.out_free  = !out_valid || out_ready;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      active_readers <= ACTV_RESET;
    end else if (cfg_we) begin
      active_readers <= cfg_data;
    end
  end

  // Command execution
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      full_mark <= 1'b0;
      overrun   <= '0;
      for (int i = 0; i < MAX_READERS; i++) tails[i] <= '0;
    end else if (ctl.accept) begin
      case (cmd)
        CMD_ADV_HEAD: begin
          if (blocked) begin
            full_mark <= 1'b1;
            if (overrun != OVR_MAX) overrun <= overrun + OVR_W'(1);
          end else begin
            head      <= head_inc;
            full_mark <= 1'b0;
          end
        end
        CMD_ADV_TAIL: begin
          if (sel_ok_in && tail_in != head) begin
            for (int i = 0; i < MAX_READERS; i++) begin
              if (32'(req_sel) == i) tails[i] <= tail_in_inc;
            end
          end
        end
        CMD_FLUSH: begin
          for (int i = 0; i < MAX_READERS; i++) tails[i] <= head;
          full_mark <= 1'b0;
        end
        default: begin
          full_mark <= full_mark;
        end
      endcase
    end
  end

  // Occupancy scan, one reader per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (ctl.accept) begin
      scan_idx <= '0;
    end else if (ctl.scan_step) begin
      scan_idx <= scan_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      sel_q    <= req_sel;
      used_acc <= '0;
    end else if (ctl.scan_step && scan_dist > used_acc) begin
      used_acc <= scan_dist;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      head_slot     <= slot_of(32'(head));
      tail_slot     <= slot_of(32'(tail_q));
      reader_empty  <= (tail_q == head);
      full_flag     <= full_mark;
      overrun_count <= overrun;
      used_slots    <= slot_of(32'(used_acc));
    end
  end

endmodule

### test/tb_multi_reader_ring_pointer_manager.sv
module tb_multi_reader_ring_pointer_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import mrrpm_pkg::*;

  localparam int RING_DEPTH   = 1024;
  localparam int RING_READERS = 4;

  typedef struct {
    cmd_t             cmd;
    logic [SEL_W-1:0] sel;
  } ring_req_t;

  typedef struct {
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] tail_slot;
    logic              reader_empty;
    logic              full_flag;
    logic [OVR_W-1:0]  overrun_count;
    logic [SLOT_W-1:0] used_slots;
  } ring_status_t;

  logic clk;
  logic rst;

  mrrpm_req_if req ();
  mrrpm_rsp_if rsp ();
  mrrpm_cfg_if cfg ();

  multi_reader_ring_pointer_manager #(
    .DEPTH       (RING_DEPTH),
    .MAX_READERS (RING_READERS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Shadow of the pointer state
  logic [SLOT_W-1:0] head_ptr;
  logic [SLOT_W-1:0] tail_ptr [RING_READERS];
  logic              full_mark;
  logic [OVR_W-1:0]  overrun_cnt;
  logic [ACTV_W-1:0] active_cfg;

  ring_req_t    pending_cmd_q [$];
  ring_status_t expected_status_q [$];
  ring_req_t    in_flight;

  bit sender_gaps;
  bit receiver_stalls;
  bit req_fired;
  int gap_left;
  int stall_left;
  int error_count;
  int results_checked;
  int refused_count;
  int wrap_count;
  int setting_count;
  int cmd_count [4];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("Timeout: requests or results stopped moving");
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [OVR_W-1:0] got,
                             input logic [OVR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (result %0d)", name, got, want,
                                results_checked));
  endtask

  // Short gaps mostly, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Apply one request to the shadow state and queue the status it reports
  task automatic predict_ring_status(input ring_req_t r);
    int unsigned       n;
    logic [SLOT_W-1:0] nxt;
    logic [SLOT_W-1:0] lag;
    logic [SLOT_W-1:0] used;
    logic              blocked;
    ring_status_t      st;
    n = (active_cfg > RING_READERS) ? RING_READERS : active_cfg;
    blocked = 1'b0;
    used = '0;
    cmd_count[r.cmd]++;
    case (r.cmd)
      CMD_ADV_HEAD: begin
        // depth is 2**SLOT_W, so the slot index wraps naturally
        nxt = head_ptr + 1'b1;
        for (int i = 0; i < n; i++)
          if (tail_ptr[i] == nxt) blocked = 1'b1;
        if (blocked) begin
          full_mark = 1'b1;
          refused_count++;
          if (overrun_cnt != OVR_MAX) overrun_cnt++;
        end else begin
          if (nxt == '0) wrap_count++;
          head_ptr = nxt;
          full_mark = 1'b0;
        end
      end
      CMD_ADV_TAIL: begin
        // select is 2 bits wide, always a real reader
        if (tail_ptr[r.sel] != head_ptr) tail_ptr[r.sel] = tail_ptr[r.sel] + 1'b1;
      end
      CMD_FLUSH: begin
        for (int i = 0; i < RING_READERS; i++) tail_ptr[i] = head_ptr;
        full_mark = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      lag = head_ptr - tail_ptr[i];
      if (lag > used) used = lag;
    end
    st.head_slot     = head_ptr;
    st.tail_slot     = tail_ptr[r.sel];
    st.reader_empty  = (tail_ptr[r.sel] == head_ptr);
    st.full_flag     = full_mark;
    st.overrun_count = overrun_cnt;
    st.used_slots    = used;
    expected_status_q.push_back(st);
  endtask

  // Request driver: predict on the accepting edge, next request at the falling edge
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      predict_ring_status(in_flight);
      req_fired = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!req.valid || req_fired) begin
      req_fired = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (pending_cmd_q.size() != 0) begin
        in_flight = pending_cmd_q.pop_front();
        req.valid <= 1'b1;
        req.cmd <= in_flight.cmd;
        req.reader_select <= in_flight.sel;
        gap_left = (sender_gaps && $urandom_range(0, 99) < 30) ? idle_span() : 0;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
      stall_left = idle_span() - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    ring_status_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      results_checked++;
      if (expected_status_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_status_q.pop_front();
        check_field("head_slot", OVR_W'(rsp.head_slot), OVR_W'(want.head_slot));
        check_field("tail_slot", OVR_W'(rsp.tail_slot), OVR_W'(want.tail_slot));
        check_field("reader_empty", OVR_W'(rsp.reader_empty), OVR_W'(want.reader_empty));
        check_field("full_flag", OVR_W'(rsp.full_flag), OVR_W'(want.full_flag));
        check_field("overrun_count", rsp.overrun_count, want.overrun_count);
        check_field("used_slots", OVR_W'(rsp.used_slots), OVR_W'(want.used_slots));
      end
    end
  end

  task automatic queue_request(input cmd_t c, input int sel);
    ring_req_t r;
    r.cmd = c;
    r.sel = SEL_W'(sel);
    pending_cmd_q.push_back(r);
  endtask

  // Run of head advances with a little noise
  task automatic queue_fill_run(input int heads, input int noise_pct);
    for (int i = 0; i < heads; i++) begin
      queue_request(CMD_ADV_HEAD, $urandom_range(0, 3));
      if ($urandom_range(0, 99) < noise_pct)
        queue_request(($urandom_range(0, 1) != 0) ? CMD_STATUS : CMD_ADV_TAIL,
                      $urandom_range(0, 3));
    end
  endtask

  task automatic queue_random_batch(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      queue_request(CMD_ADV_HEAD, $urandom_range(0, 3));
      else if (r < 78) queue_request(CMD_ADV_TAIL, $urandom_range(0, 3));
      else if (r < 94) queue_request(CMD_STATUS, $urandom_range(0, 3));
      else             queue_request(CMD_FLUSH, $urandom_range(0, 3));
    end
  endtask

  task automatic wait_idle();
    while (pending_cmd_q.size() != 0 || req.valid || expected_status_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Drain, write active_readers, then pick the idling style of the next phase
  task automatic start_phase(input logic [ACTV_W-1:0] readers);
    wait_idle();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.active_readers <= readers;
    do @(posedge clk); while (!cfg.ready);
    active_cfg = readers;
    setting_count++;
    @(negedge clk);
    cfg.valid <= 1'b0;
    sender_gaps = ($urandom_range(0, 2) != 0);
    receiver_stalls = ($urandom_range(0, 2) != 0);
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.cmd = CMD_STATUS;
    req.reader_select = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.active_readers = ACTV_RESET;
    head_ptr = '0;
    foreach (tail_ptr[i]) tail_ptr[i] = '0;
    full_mark = 1'b0;
    overrun_cnt = '0;
    active_cfg = ACTV_RESET;
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty reader, inactive reader, flush, back-to-back
    queue_request(CMD_STATUS, 0);
    queue_request(CMD_ADV_TAIL, 0);
    queue_request(CMD_ADV_HEAD, 0);
    queue_request(CMD_ADV_HEAD, 1);
    queue_request(CMD_ADV_HEAD, 2);
    queue_request(CMD_ADV_TAIL, 0);
    queue_request(CMD_ADV_TAIL, 0);
    queue_request(CMD_ADV_TAIL, 3);
    queue_request(CMD_STATUS, 3);
    queue_request(CMD_ADV_TAIL, 2);
    queue_request(CMD_FLUSH, 1);
    queue_request(CMD_ADV_TAIL, 1);
    queue_request(CMD_ADV_HEAD, 3);
    queue_request(CMD_STATUS, 2);

    // One reader: build up occupancy, free a few slots, advance again
    start_phase(3'd1);
    queue_fill_run(120, 5);
    repeat (8) queue_request(CMD_ADV_TAIL, 0);
    queue_fill_run(12, 0);
    queue_random_batch(40);
    queue_request(CMD_FLUSH, 0);

    // No readers: nothing blocks the head and occupancy reads zero
    start_phase(3'd0);
    queue_random_batch(40);

    // Count above the reader limit
    start_phase(3'd7);
    queue_random_batch(50);

    // All readers, uneven tails, advanced from a non-zero head
    start_phase(3'd4);
    queue_request(CMD_FLUSH, 2);
    queue_fill_run(60, 6);
    queue_random_batch(40);

    start_phase(3'd2);
    queue_random_batch(30);
    start_phase(3'd3);
    queue_random_batch(30);
    start_phase(3'd5);
    queue_random_batch(25);
    start_phase(3'd6);
    queue_random_batch(25);
    start_phase(3'd1);
    queue_random_batch(25);

    wait_idle();
    $display("Checked %0d results: %0d status, %0d head, %0d tail, %0d flush requests",
             results_checked, cmd_count[CMD_STATUS], cmd_count[CMD_ADV_HEAD],
             cmd_count[CMD_ADV_TAIL], cmd_count[CMD_FLUSH]);
    $display("%0d reader settings, %0d head advances refused, head wrapped %0d times",
             setting_count, refused_count, wrap_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
src/mrrpm_pkg.sv
src/mrrpm_req_if.sv
src/mrrpm_rsp_if.sv
src/mrrpm_cfg_if.sv
src/mrrpm_ctrl.sv
src/mrrpm_dp.sv
src/multi_reader_ring_pointer_manager.sv
test/tb_multi_reader_ring_pointer_manager.sv
